// ----- rtl/core/tbcs_pkg.sv -----
package tbcs_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int CHUNK_BYTES     = 16384;
  localparam int GRANTS_PER_TICK = 4;
  localparam int OQ_DEPTH        = 4;
  localparam int CQ_DEPTH        = 2;

  localparam int QIW  = $clog2(QUEUE_DEPTH);
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int GW   = $clog2(GRANTS_PER_TICK + 1);
  localparam int OIW  = $clog2(OQ_DEPTH);
  localparam int OCW  = $clog2(OQ_DEPTH + 1);
  localparam int CIW  = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CCW  = $clog2(CQ_DEPTH + 1);
  localparam int ENT_W = 48;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_REQUEST = 2'd1;
  localparam logic [1:0] MODE_CANCEL  = 2'd2;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_CANCEL  = 2'd2;

  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CANCELED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [2:0] REG_LIMIT_ADDR = 3'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] task_id;
    logic [31:0] byte_count;
  } cmd_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [2:0]  status;
    logic [31:0] granted_bytes;
    logic        request_done;
    logic        last_of_run;
  } res_t;

  function automatic logic [QIW-1:0] wrap_idx(logic [QIW-1:0] base, logic [QCW-1:0] off);
    logic [QCW:0] s;
    s = {{(QCW + 1 - QIW){1'b0}}, base} + {1'b0, off};
    if (s >= (QCW + 1)'(QUEUE_DEPTH)) s = s - (QCW + 1)'(QUEUE_DEPTH);
    return s[QIW-1:0];
  endfunction

endpackage

// ----- rtl/core/tbcs_ram.sv -----
module tbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tbcs_front.sv -----
module tbcs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    mode,
  input  logic [15:0]   task_id,
  input  logic [31:0]   byte_count,
  output logic          cmd_valid,
  output tbcs_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import tbcs_pkg::*;

  cmd_t           slots [CQ_DEPTH];
  logic [CIW-1:0] wptr, rptr;
  logic [CCW-1:0] count;
  logic           keep, take, give;
  cmd_t           incoming;

  always_comb begin
    incoming.task_id    = task_id;
    incoming.byte_count = byte_count;
    keep = 1'b1;
    case (mode)
      MODE_TICK:    incoming.kind = KIND_TICK;
      MODE_REQUEST: incoming.kind = KIND_REQUEST;
      MODE_CANCEL:  incoming.kind = KIND_CANCEL;
      default: begin
        incoming.kind = KIND_TICK;
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == CCW'(CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rptr];
  assign take      = push && !full && keep;
  assign give      = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (take) slots[wptr] <= incoming;
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (take) wptr <= (wptr == CIW'(CQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (give) rptr <= (rptr == CIW'(CQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + CCW'(take) - CCW'(give);
    end
  end

endmodule

// ----- rtl/core/tbcs_outq.sv -----
module tbcs_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  tbcs_pkg::res_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tbcs_pkg::res_t rdata
);
  import tbcs_pkg::*;

  res_t           slots [OQ_DEPTH];
  logic [OIW-1:0] wptr, rptr;
  logic [OCW-1:0] count;
  logic           take, give;

  assign full  = (count == OCW'(OQ_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];
  assign take  = wr && !full;
  assign give  = pop && !empty;

  always_ff @(posedge clk) begin
    if (take) slots[wptr] <= wdata;
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (take) wptr <= (wptr == OIW'(OQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (give) rptr <= (rptr == OIW'(OQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + OCW'(take) - OCW'(give);
    end
  end

endmodule

// ----- rtl/core/tbcs_back.sv -----
module tbcs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [19:0]    cfg_data,
  output logic [19:0]    limit,
  input  logic           cmd_valid,
  input  tbcs_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           oq_wr,
  output tbcs_pkg::res_t oq_data,
  input  logic           oq_full
);
  import tbcs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_REQ  = 4'd1;
  localparam logic [3:0] S_TUP  = 4'd2;
  localparam logic [3:0] S_TRD  = 4'd3;
  localparam logic [3:0] S_TCH  = 4'd4;
  localparam logic [3:0] S_TGR  = 4'd5;
  localparam logic [3:0] S_CRD  = 4'd6;
  localparam logic [3:0] S_CCMP = 4'd7;
  localparam logic [3:0] S_SRD  = 4'd8;
  localparam logic [3:0] S_SWR  = 4'd9;
  localparam logic [3:0] S_END  = 4'd10;

  logic [3:0]       state;
  cmd_t             cur;
  logic [27:0]      token;
  logic [QIW-1:0]   head, tail;
  logic [QCW-1:0]   count;
  logic [QCW-1:0]   k;
  logic [GW-1:0]    g;
  res_t             held;
  logic             held_valid;
  logic [ENT_W-1:0] ent;
  logic [31:0]      chunk;

  logic             ram_we;
  logic [QIW-1:0]   ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic [27:0]      burst;
  logic [28:0]      tsum;
  logic [31:0]      c1, c2, rem_left;
  logic             limited;

  tbcs_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign burst    = {limit, 8'd0};
  assign limited  = (limit != '0);
  assign tsum     = {1'b0, token} + {9'd0, limit};
  assign rem_left = ent[31:0] - chunk;

  always_comb begin
    c1 = (ram_rdata[31:0] > 32'(CHUNK_BYTES)) ? 32'(CHUNK_BYTES) : ram_rdata[31:0];
    c2 = (c1 > {4'd0, burst}) ? {4'd0, burst} : c1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = {cur.task_id, cur.byte_count};
    ram_raddr = head;
    cmd_pop   = 1'b0;
    oq_wr     = 1'b0;
    oq_data   = held;
    case (state)
      S_IDLE: cmd_pop = cmd_valid;
      S_REQ: begin
        ram_we = limited && (cur.byte_count != '0) && (count != QCW'(QUEUE_DEPTH));
      end
      S_CRD:  ram_raddr = wrap_idx(head, k);
      S_SRD:  ram_raddr = wrap_idx(head, k + 1'b1);
      S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_idx(head, k);
        ram_wdata = ram_rdata;
      end
      S_TGR: begin
        if (!(limited && ({4'd0, token} < chunk)) && !(held_valid && oq_full)) begin
          oq_wr     = held_valid;
          ram_we    = (rem_left != '0);
          ram_wdata = {ent[47:32], rem_left};
        end
      end
      S_END: begin
        oq_wr               = held_valid && !oq_full;
        oq_data.last_of_run = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      limit      <= '0;
      token      <= '0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      held_valid <= 1'b0;
      k          <= '0;
      g          <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
        token <= {cfg_data, 8'd0};
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            k   <= '0;
            case (cmd.kind)
              KIND_REQUEST: state <= S_REQ;
              KIND_CANCEL:  state <= S_CRD;
              default:      state <= S_TUP;
            endcase
          end
        end
        S_REQ: begin
          held.task_id     <= cur.task_id;
          held.last_of_run <= 1'b0;
          held_valid       <= 1'b1;
          if (!limited || cur.byte_count == '0) begin
            held.status        <= ST_GRANTED;
            held.granted_bytes <= cur.byte_count;
            held.request_done  <= 1'b1;
          end else if (count == QCW'(QUEUE_DEPTH)) begin
            held.status        <= ST_FULL;
            held.granted_bytes <= '0;
            held.request_done  <= 1'b0;
          end else begin
            held.status        <= ST_QUEUED;
            held.granted_bytes <= '0;
            held.request_done  <= 1'b0;
            tail               <= wrap_idx(tail, QCW'(1));
            count              <= count + 1'b1;
          end
          state <= S_END;
        end
        S_TUP: begin
          if (limited) token <= (tsum > {1'b0, burst}) ? burst : tsum[27:0];
          g     <= '0;
          state <= S_TRD;
        end
        S_TRD: begin
          if (count == '0 || g == GW'(GRANTS_PER_TICK)) state <= S_END;
          else state <= S_TCH;
        end
        S_TCH: begin
          ent   <= ram_rdata;
          chunk <= limited ? c2 : ram_rdata[31:0];
          state <= S_TGR;
        end
        S_TGR: begin
          if (limited && ({4'd0, token} < chunk)) begin
            state <= S_END;
          end else if (!(held_valid && oq_full)) begin
            if (limited) token <= token - chunk[27:0];
            head <= wrap_idx(head, QCW'(1));
            if (rem_left != '0) tail <= wrap_idx(tail, QCW'(1));
            else count <= count - 1'b1;
            held.task_id       <= ent[47:32];
            held.status        <= ST_GRANTED;
            held.granted_bytes <= chunk;
            held.request_done  <= (rem_left == '0);
            held.last_of_run   <= 1'b0;
            held_valid         <= 1'b1;
            g                  <= g + 1'b1;
            state              <= S_TRD;
          end
        end
        S_CRD: begin
          if (k == count) begin
            held.task_id       <= cur.task_id;
            held.status        <= ST_NOTFOUND;
            held.granted_bytes <= '0;
            held.request_done  <= 1'b0;
            held.last_of_run   <= 1'b0;
            held_valid         <= 1'b1;
            state              <= S_END;
          end else begin
            state <= S_CCMP;
          end
        end
        S_CCMP: begin
          if (ram_rdata[47:32] == cur.task_id) begin
            state <= S_SRD;
          end else begin
            k     <= k + 1'b1;
            state <= S_CRD;
          end
        end
        S_SRD: begin
          if ({1'b0, k} + 1'b1 >= {1'b0, count}) begin
            tail               <= (tail == '0) ? QIW'(QUEUE_DEPTH - 1) : tail - 1'b1;
            count              <= count - 1'b1;
            held.task_id       <= cur.task_id;
            held.status        <= ST_CANCELED;
            held.granted_bytes <= '0;
            held.request_done  <= 1'b0;
            held.last_of_run   <= 1'b0;
            held_valid         <= 1'b1;
            state              <= S_END;
          end else begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          k     <= k + 1'b1;
          state <= S_SRD;
        end
        S_END: begin
          if (!held_valid) begin
            state <= S_IDLE;
          end else if (!oq_full) begin
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= QCW'(QUEUE_DEPTH))
    else $error("pending queue count over depth");
  assert property (@(posedge clk) disable iff (rst) token <= burst)
    else $error("bucket above burst");
  assert property (@(posedge clk) disable iff (rst) state == S_IDLE |-> !held_valid)
    else $error("result left behind at end of item");
  assert property (@(posedge clk) disable iff (rst) oq_wr |-> !oq_full)
    else $error("result written into full queue");

endmodule

// ----- rtl/core/token_bucket_chunk_shaper_unit.sv -----
// Token bucket shaper with a queue of pending transfers.
// Input channel: drive mode/task_id/byte_count with push; the request is taken
// when push is high and full is low. Mode 0 is a tick, 1 a transfer request,
// 2 a cancel; mode 3 is taken and dropped. Two requests can wait in front.
// Result channel: while empty is low the oldest result is on the result ports;
// pop takes it. last_of_run marks the final result of each request.
// Config: APB write of limit_kbps at address 0 reloads the bucket to its burst;
// write it only while the block is idle.
// Sequencing: one request is worked at a time by a sequencer sharing the single
// pending-queue RAM. A transfer request is checked and its result written out
// once it is taken by an idle sequencer. A tick refills the bucket and then
// grants up to 4 chunks, stopping early when the bucket runs short.
// A cancel searches the queue entry by entry, then shifts later entries up.
// Reset clears the bucket, limit and queue pointers; queue storage is kept.
// When the receiver stalls, up to 5 results are held (4 in the result queue,
// one in the sequencer); then the sequencer waits and the input queue fills,
// raising full.
module token_bucket_chunk_shaper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [15:0] task_id,
  input  logic [31:0] byte_count,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] task_id_out,
  output logic [2:0]  status,
  output logic [31:0] granted_bytes,
  output logic        request_done,
  output logic        last_of_run
);
  import tbcs_pkg::*;

  logic        cmd_valid, cmd_pop, oq_wr, oq_full, cfg_we;
  cmd_t        cmd;
  res_t        oq_wdata, oq_rdata;
  logic [19:0] limit;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_LIMIT_ADDR[2]);
  assign prdata = (paddr[2] == REG_LIMIT_ADDR[2]) ? {12'd0, limit} : '0;

  tbcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .task_id    (task_id),
    .byte_count (byte_count),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  tbcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (pwdata[19:0]),
    .limit     (limit),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .oq_wr     (oq_wr),
    .oq_data   (oq_wdata),
    .oq_full   (oq_full)
  );

  tbcs_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (oq_wr),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .empty (empty),
    .rdata (oq_rdata)
  );

  assign task_id_out   = oq_rdata.task_id;
  assign status        = oq_rdata.status;
  assign granted_bytes = oq_rdata.granted_bytes;
  assign request_done  = oq_rdata.request_done;
  assign last_of_run   = oq_rdata.last_of_run;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import tbcs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = REG_LIMIT_ADDR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = MODE_TICK;
  logic [15:0] task_id = '0;
  logic [31:0] byte_count = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] task_id_out;
  logic [2:0]  status;
  logic [31:0] granted_bytes;
  logic        request_done;
  logic        last_of_run;

  token_bucket_chunk_shaper_unit uut (.*);

  always #6 clk = ~clk;

  // shaper state mirror
  logic [19:0] rate_kbps;
  logic [31:0] bucket;
  logic [15:0] wait_task [QUEUE_DEPTH];
  logic [31:0] wait_bytes [QUEUE_DEPTH];
  int          q_head, q_tail, q_cnt;

  res_t pending_results[$];
  int   errors = 0;
  bit   quiet = 1'b0;

  typedef struct {
    bit          do_cfg;
    logic [19:0] lim;
    logic [1:0]  md;
    logic [15:0] id;
    logic [31:0] nbytes;
    bit          typed;
    res_t        res;
  } step_t;

  function automatic res_t mk(logic [15:0] id, logic [2:0] st, logic [31:0] b, logic d);
    res_t r;
    r.task_id = id; r.status = st; r.granted_bytes = b; r.request_done = d;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] burst_of();
    return ({12'd0, rate_kbps} * 32'd256) & 32'h0FFF_FFFF;
  endfunction

  task automatic enqueue_task(logic [15:0] id, logic [31:0] b);
    wait_task[q_tail] = id;
    wait_bytes[q_tail] = b;
    q_tail = (q_tail + 1) % QUEUE_DEPTH;
    q_cnt++;
  endtask

  task automatic shape_item(logic [1:0] md, logic [15:0] id, logic [31:0] b);
    res_t out[$];
    int k, src, dst;
    logic [31:0] brst, chunk, rem, sum;
    logic [15:0] hid;
    bit hit;
    if (md == MODE_REQUEST) begin
      if (rate_kbps == 0 || b == 0) out = {out, mk(id, ST_GRANTED, b, 1'b1)};
      else if (q_cnt >= QUEUE_DEPTH) out = {out, mk(id, ST_FULL, 0, 1'b0)};
      else begin
        enqueue_task(id, b);
        out = {out, mk(id, ST_QUEUED, 0, 1'b0)};
      end
    end else if (md == MODE_CANCEL) begin
      hit = 1'b0;
      for (k = 0; k < q_cnt; k++)
        if (wait_task[(q_head + k) % QUEUE_DEPTH] == id) begin
          hit = 1'b1;
          break;
        end
      if (hit) begin
        for (; k + 1 < q_cnt; k++) begin
          dst = (q_head + k) % QUEUE_DEPTH;
          src = (q_head + k + 1) % QUEUE_DEPTH;
          wait_task[dst] = wait_task[src];
          wait_bytes[dst] = wait_bytes[src];
        end
        q_tail = (q_tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        q_cnt--;
        out = {out, mk(id, ST_CANCELED, 0, 1'b0)};
      end else out = {out, mk(id, ST_NOTFOUND, 0, 1'b0)};
    end else if (md == MODE_TICK) begin
      brst = burst_of();
      if (rate_kbps != 0) begin
        sum = bucket + rate_kbps;
        bucket = (sum > brst) ? brst : sum;
      end
      for (k = 0; k < GRANTS_PER_TICK && q_cnt != 0; k++) begin
        hid = wait_task[q_head];
        rem = wait_bytes[q_head];
        chunk = rem;
        if (rate_kbps != 0) begin
          if (chunk > CHUNK_BYTES) chunk = CHUNK_BYTES;
          if (chunk > brst) chunk = brst;
          if (bucket < chunk) break;
          bucket -= chunk;
        end
        q_head = (q_head + 1) % QUEUE_DEPTH;
        q_cnt--;
        rem -= chunk;
        if (rem != 0) enqueue_task(hid, rem);
        out = {out, mk(hid, ST_GRANTED, chunk, rem == 0)};
      end
    end
    foreach (out[i]) begin
      out[i].last_of_run = (i == out.size() - 1);
      pending_results = {pending_results, out[i]};
    end
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_limit(logic [19:0] lim);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= REG_LIMIT_ADDR;
    pwdata <= {$urandom_range(4095), lim};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    rate_kbps = lim;
    bucket = burst_of();
  endtask

  // returns with push still high; caller lowers it when done
  task automatic send(logic [1:0] md, logic [15:0] id, logic [31:0] b, bit typed, res_t r);
    int n;
    n = 0;
    while (!quiet && $urandom_range(99) < 27) n++;
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    push <= 1'b1; mode <= md; task_id <= id; byte_count <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    if (typed) begin
      shape_item(md, id, b);
      pending_results.delete(pending_results.size() - 1);
      pending_results = {pending_results, r};
    end else shape_item(md, id, b);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pop <= quiet ? 1'b1 : ($urandom_range(99) >= 27);
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected request result, expected none, actual task %0h status %0d",
                 $time, task_id_out, status);
        errors++;
      end else begin
        res_t e;
        e = pending_results[0];
        pending_results.delete(0);
        check_field("task_id_out", e.task_id, task_id_out);
        check_field("status", e.status, status);
        check_field("granted_bytes", e.granted_bytes, granted_bytes);
        check_field("request_done", e.request_done, request_done);
        check_field("last_of_run", e.last_of_run, last_of_run);
      end
    end
  end

  step_t steps[] = '{
    '{0, 0, MODE_REQUEST, 16'hFFFF, 32'hFFFF_FFFF, 1, mk(16'hFFFF, ST_GRANTED, 32'hFFFF_FFFF, 1)},
    '{0, 0, MODE_REQUEST, 16'h0000, 32'h0, 1, mk(16'h0000, ST_GRANTED, 0, 1)},
    '{0, 0, MODE_TICK, 16'h0, 32'h0, 0, '0},
    '{0, 0, 2'd3, 16'hAAAA, 32'h5555_5555, 0, '0},
    '{0, 0, MODE_CANCEL, 16'h1234, 32'h0, 1, mk(16'h1234, ST_NOTFOUND, 0, 0)},
    '{1, 1, MODE_REQUEST, 16'd1, 32'd300, 1, mk(16'd1, ST_QUEUED, 0, 0)},
    '{0, 0, MODE_REQUEST, 16'd2, 32'd0, 1, mk(16'd2, ST_GRANTED, 0, 1)},
    '{0, 0, MODE_TICK, 16'h0, 32'h0, 0, '0},
    '{0, 0, MODE_TICK, 16'h0, 32'h0, 0, '0},
    '{0, 0, MODE_CANCEL, 16'd1, 32'h0, 1, mk(16'd1, ST_CANCELED, 0, 0)},
    '{0, 0, MODE_CANCEL, 16'd1, 32'h0, 1, mk(16'd1, ST_NOTFOUND, 0, 0)},
    '{1, 20'hFFFFF, MODE_REQUEST, 16'd3, 32'd100000, 1, mk(16'd3, ST_QUEUED, 0, 0)},
    '{0, 0, MODE_REQUEST, 16'd3, 32'd5, 1, mk(16'd3, ST_QUEUED, 0, 0)},
    '{0, 0, MODE_REQUEST, 16'd9, 32'hFFFF_FFFF, 1, mk(16'd9, ST_QUEUED, 0, 0)},
    '{0, 0, MODE_TICK, 16'h0, 32'h0, 0, '0},
    '{0, 0, MODE_CANCEL, 16'd3, 32'h0, 1, mk(16'd3, ST_CANCELED, 0, 0)},
    '{0, 0, MODE_TICK, 16'h0, 32'h0, 0, '0},
    '{1, 0, MODE_REQUEST, 16'd4, 32'd50, 1, mk(16'd4, ST_GRANTED, 32'd50, 1)},
    '{0, 0, MODE_TICK, 16'h0, 32'h0, 0, '0},
    '{0, 0, MODE_TICK, 16'h0, 32'h0, 0, '0}
  };

  initial begin
    logic [19:0] limits [6];
    logic [1:0]  md;
    logic [15:0] id;
    logic [31:0] b;
    int r;
    rate_kbps = '0; bucket = '0; q_head = 0; q_tail = 0; q_cnt = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (steps[i]) begin
      if (steps[i].do_cfg) begin
        push <= 1'b0;
        settle();
        write_limit(steps[i].lim);
      end
      send(steps[i].md, steps[i].id, steps[i].nbytes, steps[i].typed, steps[i].res);
    end
    limits = '{20'd1, 20'd300, 20'hFFFFF, 20'd0, 20'($urandom_range(1, 20'hFFFFF)), 20'd40};
    foreach (limits[p]) begin
      push <= 1'b0;
      settle();
      write_limit(limits[p]);
      quiet = (p == 2);
      for (int n = 0; n < 75; n++) begin
        r = $urandom_range(99);
        id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
        case ($urandom_range(5))
          0: b = 32'h0;
          1: b = $urandom;
          2: b = $urandom_range(1, 300);
          default: b = $urandom_range(1, 70000);
        endcase
        if (r < 45) md = MODE_REQUEST;
        else if (r < 82) md = MODE_TICK;
        else if (r < 96) md = MODE_CANCEL;
        else md = 2'd3;
        send(md, id, b, 0, '0);
      end
    end
    push <= 1'b0;
    quiet = 1'b0;
    settle();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- token_bucket_chunk_shaper_unit.f -----
rtl/core/tbcs_pkg.sv
rtl/core/tbcs_ram.sv
rtl/core/tbcs_front.sv
rtl/core/tbcs_outq.sv
rtl/core/tbcs_back.sv
rtl/core/token_bucket_chunk_shaper_unit.sv
dv/tb.sv
